// ===== rtl/blm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level monitor package
// Shared widths, register indexes, reset values and control structs.
// ----------------------------------------------------------------------------
package blm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 20;
    localparam int MV_W     = 16;
    localparam int PCT_W    = 7;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int NUM_W    = MV_W + PCT_W;
    localparam int IDX_W    = 3;
    localparam int KW       = 3;

    localparam logic [KW-1:0]     DIV_TOP  = KW'(PCT_W - 1);
    localparam logic [PCT_W-1:0]  PCT_FULL = PCT_W'(100);

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN      = 3'd0,
        REG_MIN_MV    = 3'd1,
        REG_MAX_MV    = 3'd2,
        REG_CAL_LEN   = 3'd3,
        REG_LOW_PCT   = 3'd4
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] RST_GAIN    = 20'd46388;
    localparam logic [MV_W-1:0]   RST_MIN_MV  = 16'd3000;
    localparam logic [MV_W-1:0]   RST_MAX_MV  = 16'd4200;
    localparam logic [MV_W-1:0]   RST_CAL_LEN = 16'd50;
    localparam logic [PCT_W-1:0]  RST_LOW_PCT = 7'd25;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [MV_W-1:0]   min_mv;
        logic [MV_W-1:0]   max_mv;
        logic [MV_W-1:0]   cal_len;
        logic [PCT_W-1:0]  low_pct;
    } t_cfg;

    typedef struct packed {
        logic          load_in;
        logic          mul;
        logic          upd;
        logic          prep;
        logic          div;
        logic [KW-1:0] div_k;
        logic          load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/battery_level_monitor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level monitor core
// Scales 12-bit ADC beats to millivolts and reports held voltage and charge.
//
// Each beat on the slave stream carries one ADC sample. The block answers
// with exactly one beat on the master stream holding the held voltage, the
// charge percent and two flags. From acceptance to a loaded result, a sample
// goes through a multiply, a state update, a prepare step, a seven-step
// restoring divide that forms the percent quotient bit by bit, and a step
// that loads the output register.
// A new sample is accepted only once the previous one is loaded into the
// output register, since one sample is in work at a time.
// The result sits in an output register, so the next sample is accepted
// while a result waits; when the receiver stalls, the block holds its
// finished result until the output register is free.
// Reset clears the calibration state and loads the default register values.
// Write registers via the write port only while idle; the block won't check.
// ----------------------------------------------------------------------------
module battery_level_monitor_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [blm_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [blm_pkg::GAIN_W-1:0]    i_cfg_wdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // adc_sample [11:0], zero [15:12]
    input  wire logic [15:0]                   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // voltage_mv [15:0], percent [22:16], zero [23]
    output logic [23:0]                        m_axis_tdata,
    // low_battery [0], calibrating [1]
    output logic [1:0]                         m_axis_tuser
);
    import blm_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    logic [MV_W-1:0]  w_mv;
    logic [PCT_W-1:0] w_pct;
    logic             w_low;
    logic             w_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain    <= RST_GAIN;
            r_cfg.min_mv  <= RST_MIN_MV;
            r_cfg.max_mv  <= RST_MAX_MV;
            r_cfg.cal_len <= RST_CAL_LEN;
            r_cfg.low_pct <= RST_LOW_PCT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GAIN:    r_cfg.gain    <= i_cfg_wdata;
                REG_MIN_MV:  r_cfg.min_mv  <= i_cfg_wdata[MV_W-1:0];
                REG_MAX_MV:  r_cfg.max_mv  <= i_cfg_wdata[MV_W-1:0];
                REG_CAL_LEN: r_cfg.cal_len <= i_cfg_wdata[MV_W-1:0];
                REG_LOW_PCT: r_cfg.low_pct <= i_cfg_wdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    blm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    blm_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_sample      (s_axis_tdata[SAMPLE_W-1:0]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_voltage_mv  (w_mv),
        .o_percent     (w_pct),
        .o_low_battery (w_low),
        .o_calibrating (w_cal)
    );

    assign m_axis_tdata = {1'b0, w_pct, w_mv};
    assign m_axis_tuser = {w_cal, w_low};

endmodule
`default_nettype wire

// ===== rtl/blm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level monitor controller
// Sequences one sample through multiply, update, prepare, divide and output.
// ----------------------------------------------------------------------------
module blm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  var  blm_pkg::t_sts i_sts,
    output blm_pkg::t_cmd      o_cmd
);
    import blm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_UPD  = 6'b000100,
        S_PREP = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [KW-1:0] r_div_k, n_div_k;

    always_comb begin
        n_state = r_state;
        n_div_k = r_div_k;
        o_cmd   = '0;
        o_cmd.div_k = r_div_k;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_div_k = DIV_TOP;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (r_div_k == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_div_k = r_div_k - 1'b1;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_div_k <= '0;
        end else begin
            r_state <= n_state;
            r_div_k <= n_div_k;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/blm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level monitor datapath
// Scaling multiplier, calibration state, percent divider and output register.
// ----------------------------------------------------------------------------
module blm_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  var  blm_pkg::t_cfg                 i_cfg,
    input  var  blm_pkg::t_cmd                 i_cmd,
    output blm_pkg::t_sts                      o_sts,
    input  wire logic [blm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [blm_pkg::MV_W-1:0]           o_voltage_mv,
    output logic [blm_pkg::PCT_W-1:0]          o_percent,
    output logic                               o_low_battery,
    output logic                               o_calibrating
);
    import blm_pkg::*;

    logic [SAMPLE_W-1:0] r_sample;
    logic [PROD_W-1:0]   r_prod;
    logic [MV_W-1:0]     r_cal_count;
    logic                r_cal_done;
    logic [MV_W-1:0]     r_ceiling;
    logic [MV_W-1:0]     r_held;
    logic                r_calib;
    logic                r_zero;
    logic                r_full;
    logic [NUM_W-1:0]    r_rem;
    logic [MV_W-1:0]     r_span;
    logic [PCT_W-1:0]    r_quot;
    logic                r_out_valid;
    logic [MV_W-1:0]     r_out_mv;
    logic [PCT_W-1:0]    r_out_pct;
    logic                r_out_low;
    logic                r_out_cal;

    logic [MV_W-1:0]     w_reading;
    logic [MV_W-1:0]     w_cnt_inc;
    logic [MV_W-1:0]     w_diff;
    logic [MV_W-1:0]     w_span;
    logic [NUM_W-1:0]    w_shifted;
    logic [PCT_W-1:0]    w_pct;

    // The product of a 12-bit sample and a 20-bit gain never exceeds 32 bits,
    // so its upper half is the 16-bit reading, with the lower half dropped.
    assign w_reading = r_prod[PROD_W-1 -: MV_W];
    assign w_cnt_inc = r_cal_count + 1'b1;
    assign w_diff    = r_held - i_cfg.min_mv;
    assign w_span    = i_cfg.max_mv - i_cfg.min_mv;
    assign w_shifted = NUM_W'(r_span) << i_cmd.div_k;
    assign w_pct     = r_zero ? '0 : (r_full ? PCT_FULL : r_quot);

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_sample) * PROD_W'(i_cfg.gain);
        end
        if (i_cmd.prep) begin
            r_zero <= (i_cfg.max_mv <= i_cfg.min_mv) || (r_held <= i_cfg.min_mv);
            r_full <= (w_diff >= w_span);
            r_rem  <= NUM_W'(w_diff) * NUM_W'(PCT_FULL);
            r_span <= w_span;
            r_quot <= '0;
        end
        if (i_cmd.div) begin
            if (r_rem >= w_shifted) begin
                r_rem <= r_rem - w_shifted;
                r_quot[i_cmd.div_k] <= 1'b1;
            end
        end
        if (i_cmd.upd) begin
            r_calib <= !r_cal_done;
        end
        if (i_cmd.load_out) begin
            r_out_mv  <= r_held;
            r_out_pct <= w_pct;
            r_out_low <= !r_calib && (w_pct <= i_cfg.low_pct);
            r_out_cal <= r_calib;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_count <= '0;
            r_cal_done  <= 1'b0;
            r_ceiling   <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.upd) begin
                if (!r_cal_done) begin
                    r_held      <= w_reading;
                    r_cal_count <= w_cnt_inc;
                    if (w_cnt_inc >= i_cfg.cal_len) begin
                        r_cal_done <= 1'b1;
                        r_ceiling  <= w_reading;
                    end
                end else if (w_reading <= r_ceiling) begin
                    r_held <= w_reading;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_voltage_mv  = r_out_mv;
    assign o_percent     = r_out_pct;
    assign o_low_battery = r_out_low;
    assign o_calibrating = r_out_cal;

endmodule
`default_nettype wire
